// File: rtl/cfb_pkg.sv
// Shared types and constants for the command frame builder.
// No dependencies; imported by the builder, serializer, top, checker and testbench.
`timescale 1ns / 1ps

package cfb_pkg;

  localparam int MAX_RESULTS = 7;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);
  localparam int PTR_W = $clog2(MAX_RESULTS);

  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  localparam logic [5:0] LAST_INDEX     = 6'd39;
  localparam logic [5:0] LAST_SET_INDEX = 6'd23;
  localparam logic [7:0] SET_BASE       = 8'h80;
  localparam logic [7:0] GET_BASE       = 8'h01;

  localparam logic [7:0] CHAR_S = 8'h73;
  localparam logic [7:0] CHAR_N = 8'h6E;
  localparam logic [7:0] CHAR_P = 8'h70;

  localparam logic [15:0] HDR_SUM = 16'(CHAR_S) + 16'(CHAR_N) + 16'(CHAR_P);

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_INDEX  = 2'd1,
    ST_NO_FRAME   = 2'd2,
    ST_START_OPEN = 2'd3
  } status_t;

  typedef struct packed {
    logic [CNT_W-1:0]                 count;
    logic [MAX_RESULTS-1:0][7:0]      bytes;
    logic                             has_sum;
    status_t                          status;
  } burst_t;

endpackage

// File: rtl/cfb_in_if.sv
// Request channel of the frame builder: start and payload requests.
// Depends on nothing.
`timescale 1ns / 1ps

interface cfb_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [5:0] cmd_index;
  logic [7:0] payload_len;
  logic [7:0] data_byte;

  modport source (output valid, opcode, cmd_index, payload_len, data_byte, input ready);
  modport sink   (input valid, opcode, cmd_index, payload_len, data_byte, output ready);
endinterface

// File: rtl/cfb_out_if.sv
// Byte stream channel of the frame builder.
// Depends on nothing.
`timescale 1ns / 1ps

interface cfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;
  logic       run_last;
  logic [1:0] status;

  modport source (output valid, out_byte, frame_end, run_last, status, input ready);
  modport sink   (input valid, out_byte, frame_end, run_last, status, output ready);
endinterface

// File: rtl/cfb_builder.sv
// Frame state and request decode: turns one request into a burst of bytes.
// Depends on cfb_pkg.
`timescale 1ns / 1ps

module cfb_builder
  import cfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       opcode,
  input  logic [5:0] cmd_index,
  input  logic [7:0] payload_len,
  input  logic [7:0] data_byte,
  output burst_t     burst
);

  logic        frame_open, frame_open_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [15:0] running_sum, running_sum_next;

  logic [7:0]  code;
  logic [15:0] sum_hdr;
  logic [15:0] sum_data;
  logic [7:0]  left_dec;

  always_comb begin
    if (cmd_index <= LAST_SET_INDEX) begin
      code = SET_BASE + {2'b00, cmd_index};
    end else begin
      code = GET_BASE + {2'b00, cmd_index} - {2'b00, LAST_SET_INDEX} - 8'd1;
    end
    sum_hdr  = HDR_SUM + {8'h00, code} + {8'h00, payload_len};
    sum_data = running_sum + {8'h00, data_byte};
    left_dec = bytes_left - 8'd1;

    burst            = '0;
    burst.count      = CNT_W'(1);
    burst.status     = ST_OK;
    frame_open_next  = frame_open;
    bytes_left_next  = bytes_left;
    running_sum_next = running_sum;

    if (opcode == OP_START) begin
      if (frame_open) begin
        burst.status = ST_START_OPEN;
      end else if (cmd_index > LAST_INDEX) begin
        burst.status = ST_BAD_INDEX;
      end else begin
        burst.bytes[0] = CHAR_S;
        burst.bytes[1] = CHAR_N;
        burst.bytes[2] = CHAR_P;
        burst.bytes[3] = code;
        burst.bytes[4] = payload_len;
        if (payload_len == 8'd0) begin
          burst.bytes[5]   = sum_hdr[15:8];
          burst.bytes[6]   = sum_hdr[7:0];
          burst.count      = CNT_W'(7);
          burst.has_sum    = 1'b1;
          running_sum_next = '0;
        end else begin
          burst.count      = CNT_W'(5);
          frame_open_next  = 1'b1;
          bytes_left_next  = payload_len;
          running_sum_next = sum_hdr;
        end
      end
    end else begin
      if (!frame_open) begin
        burst.status = ST_NO_FRAME;
      end else begin
        burst.bytes[0] = data_byte;
        if (left_dec == 8'd0) begin
          burst.bytes[1]   = sum_data[15:8];
          burst.bytes[2]   = sum_data[7:0];
          burst.count      = CNT_W'(3);
          burst.has_sum    = 1'b1;
          frame_open_next  = 1'b0;
          bytes_left_next  = '0;
          running_sum_next = '0;
        end else begin
          bytes_left_next  = left_dec;
          running_sum_next = sum_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open  <= 1'b0;
      bytes_left  <= '0;
      running_sum <= '0;
    end else if (accept) begin
      frame_open  <= frame_open_next;
      bytes_left  <= bytes_left_next;
      running_sum <= running_sum_next;
    end
  end

endmodule

// File: rtl/cfb_serializer.sv
// Result register: holds one burst and hands its bytes out one per cycle while the receiver is ready.
// Depends on cfb_pkg.
`timescale 1ns / 1ps

module cfb_serializer
  import cfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  burst_t     burst_in,
  output logic       load_ready,
  output logic       valid,
  input  logic       ready,
  output logic [7:0] out_byte,
  output logic       frame_end,
  output logic       run_last,
  output logic [1:0] status
);

  burst_t           burst;
  logic             busy;
  logic [PTR_W-1:0] ptr;
  logic             last_pos;

  assign last_pos   = ptr == PTR_W'(burst.count - CNT_W'(1));
  assign load_ready = !busy || (ready && last_pos);
  assign valid      = busy;
  assign out_byte   = burst.bytes[ptr];
  assign frame_end  = burst.has_sum && last_pos;
  assign run_last   = last_pos;
  assign status     = burst.status;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ptr  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      ptr  <= '0;
    end else if (busy && ready) begin
      if (last_pos) begin
        busy <= 1'b0;
      end else begin
        ptr <= ptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      burst <= burst_in;
    end
  end

endmodule

// File: rtl/command_frame_builder_sum16.sv
// Command frame builder: start and payload requests in, framed byte stream out.
// Uses the channel interfaces on its ports. Instantiates cfb_builder and cfb_serializer.
//
// A start request (opcode 0) emits 's','n','p', the command code and the length;
// with length zero the two checksum bytes follow at once. Each payload request
// (opcode 1) emits its byte, and the last one of a frame also emits the 16-bit
// sum of all frame bytes, high byte first, with frame_end on the low byte.
// Bad requests give a single result with a nonzero status and change nothing.
// run_last marks the final result of each request.
// The first result of a request is valid the cycle after the request is taken.
// A request is taken in any cycle in which the result register is empty or
// is handing out its last byte to a ready receiver, so a request waits for
// the last byte of the burst ahead. Results per request: one per payload byte,
// five or seven for a start, three for the closing byte, one for a bad request.
// A stalled receiver holds the current byte and blocks new requests.
// Reset (synchronous) closes any open frame and drops the pending burst.
`timescale 1ns / 1ps

module command_frame_builder_sum16
  import cfb_pkg::*;
(
  input logic       clk,
  input logic       rst,
  cfb_in_if.sink    cmd,
  cfb_out_if.source frame
);

  burst_t burst;
  logic   load_ready;
  logic   accept;

  assign cmd.ready = load_ready;
  assign accept    = cmd.valid && load_ready;

  cfb_builder u_builder (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .opcode      (cmd.opcode),
    .cmd_index   (cmd.cmd_index),
    .payload_len (cmd.payload_len),
    .data_byte   (cmd.data_byte),
    .burst       (burst)
  );

  cfb_serializer u_serializer (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .burst_in   (burst),
    .load_ready (load_ready),
    .valid      (frame.valid),
    .ready      (frame.ready),
    .out_byte   (frame.out_byte),
    .frame_end  (frame.frame_end),
    .run_last   (frame.run_last),
    .status     (frame.status)
  );

endmodule

// File: verif/cfb_frame_checker.sv
// Frame checker for the command frame builder: predicts the byte stream of each
// accepted request and compares it with the output channel, field by field.
// Depends on cfb_pkg, cfb_in_if and cfb_out_if.
`timescale 1ns / 1ps

module cfb_frame_checker
  import cfb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  cfb_in_if    cmd,
  cfb_out_if   frame,
  output int   mismatches,
  output int   pending
);

  typedef struct {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       run_last;
    status_t    status;
  } frame_result_t;

  frame_result_t frame_bytes_due[$];

  logic        frame_open;
  logic [7:0]  bytes_left;
  logic [15:0] running_sum;

  task automatic push_frame_byte(input logic [7:0] value, input logic last);
    running_sum = running_sum + 16'(value);
    frame_bytes_due.push_back('{value, 1'b0, last, ST_OK});
  endtask

  task automatic push_checksum();
    frame_bytes_due.push_back('{running_sum[15:8], 1'b0, 1'b0, ST_OK});
    frame_bytes_due.push_back('{running_sum[7:0], 1'b1, 1'b1, ST_OK});
    frame_open  = 1'b0;
    bytes_left  = '0;
    running_sum = '0;
  endtask

  task automatic push_error(input status_t code);
    frame_bytes_due.push_back('{8'h00, 1'b0, 1'b1, code});
  endtask

  task automatic build_frame(input logic op, input logic [5:0] idx,
                             input logic [7:0] len, input logic [7:0] data);
    logic [7:0] code;
    if (op == OP_START) begin
      if (frame_open) begin
        push_error(ST_START_OPEN);
      end else if (idx > LAST_INDEX) begin
        push_error(ST_BAD_INDEX);
      end else begin
        if (idx <= LAST_SET_INDEX) begin
          code = SET_BASE + 8'(idx);
        end else begin
          code = GET_BASE + 8'(idx) - 8'(LAST_SET_INDEX) - 8'd1;
        end
        running_sum = '0;
        push_frame_byte(CHAR_S, 1'b0);
        push_frame_byte(CHAR_N, 1'b0);
        push_frame_byte(CHAR_P, 1'b0);
        push_frame_byte(code, 1'b0);
        push_frame_byte(len, len != 8'd0);
        if (len == 8'd0) begin
          push_checksum();
        end else begin
          frame_open = 1'b1;
          bytes_left = len;
        end
      end
    end else if (!frame_open) begin
      push_error(ST_NO_FRAME);
    end else begin
      bytes_left = bytes_left - 8'd1;
      push_frame_byte(data, bytes_left != 8'd0);
      if (bytes_left == 8'd0) begin
        push_checksum();
      end
    end
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    logic          bad;
    if (rst) begin
      frame_open  = 1'b0;
      bytes_left  = '0;
      running_sum = '0;
      frame_bytes_due.delete();
      mismatches <= 0;
    end else begin
      if (frame.valid && frame.ready) begin
        if (frame_bytes_due.size() == 0) begin
          $error("unexpected output byte %02h with no request pending", frame.out_byte);
          mismatches <= mismatches + 1;
        end else begin
          want = frame_bytes_due.pop_front();
          bad  = 1'b0;
          if (frame.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, frame.out_byte);
            bad = 1'b1;
          end
          if (frame.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0b, got %0b", want.frame_end, frame.frame_end);
            bad = 1'b1;
          end
          if (frame.run_last !== want.run_last) begin
            $error("run_last: expected %0b, got %0b", want.run_last, frame.run_last);
            bad = 1'b1;
          end
          if (frame.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, frame.status);
            bad = 1'b1;
          end
          if (bad) begin
            mismatches <= mismatches + 1;
          end
        end
      end
      if (cmd.valid && cmd.ready) begin
        build_frame(cmd.opcode, cmd.cmd_index, cmd.payload_len, cmd.data_byte);
      end
    end
    pending <= frame_bytes_due.size();
  end

endmodule

// File: verif/command_frame_builder_sum16_tb.sv
// Testbench top for command_frame_builder_sum16: directed and random requests
// under several idle and stall phases, verdict from cfb_frame_checker.
// Depends on cfb_pkg, cfb_in_if, cfb_out_if, cfb_frame_checker and the block.
`timescale 1ns / 1ps

module command_frame_builder_sum16_tb;
  import cfb_pkg::*;

  localparam int RANDOM_ITEMS   = 210;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 16;

  logic clk;
  logic rst;

  cfb_in_if  cmd();
  cfb_out_if frame();

  int mismatches;
  int pending;
  int idle_pct;
  int stall_pct;
  int sent;
  int directed_items;
  int results_seen;
  int frames_seen;
  int errors_seen;
  int quiet_cycles;

  int idle_tbl[4]  = '{0, 52, 0, 17};
  int stall_tbl[4] = '{0, 0, 52, 17};

  command_frame_builder_sum16 i_dut (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .frame (frame)
  );

  cfb_frame_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .frame      (frame),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    frame.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && frame.valid && frame.ready) begin
      results_seen++;
      if (frame.frame_end) frames_seen++;
      if (frame.status != ST_OK) errors_seen++;
    end
    if (rst || (cmd.valid && cmd.ready) || (frame.valid && frame.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input logic op, input logic [5:0] idx,
                              input logic [7:0] len, input logic [7:0] data);
    while ($urandom_range(0, 99) < idle_pct) begin
      cmd.valid  <= 1'b0;
      cmd.opcode <= 1'($urandom_range(0, 1));
      @(posedge clk);
    end
    cmd.valid       <= 1'b1;
    cmd.opcode      <= op;
    cmd.cmd_index   <= idx;
    cmd.payload_len <= len;
    cmd.data_byte   <= data;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_start(input logic [5:0] idx, input logic [7:0] len);
    send_request(OP_START, idx, len, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_data(input logic [7:0] data);
    send_request(OP_DATA, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)), data);
  endtask

  // hold off new requests until the stream has caught up
  task automatic drain();
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_frame();
    int len;
    case ($urandom_range(0, 9))
      0: send_data(8'($urandom_range(0, 255)));
      1: send_start(6'($urandom_range(40, 63)), 8'($urandom_range(0, 255)));
      default: ;
    endcase
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
    send_start(6'($urandom_range(0, 39)), 8'(len));
    for (int n = 0; n < len; n++) begin
      if ($urandom_range(0, 11) == 0) begin
        send_start(6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
      end
      send_data(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    rst             <= 1'b1;
    cmd.valid       <= 1'b0;
    cmd.opcode      <= OP_START;
    cmd.cmd_index   <= '0;
    cmd.payload_len <= '0;
    cmd.data_byte   <= '0;
    idle_pct  = 0;
    stall_pct = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_data(8'hFF);
    send_data(8'h00);
    send_start(6'd40, 8'hFF);
    send_start(6'd63, 8'hAA);
    send_start(6'd0, 8'd0);
    send_start(6'd23, 8'd0);
    send_start(6'd24, 8'd0);
    send_start(6'd39, 8'd0);
    send_start(6'd12, 8'd2);
    send_start(6'd63, 8'hFF);
    send_data(8'h00);
    send_data(8'hFF);
    send_start(6'd30, 8'd1);
    send_data(8'h55);
    send_start(6'd5, 8'd3);
    send_data(8'hA5);
    send_start(6'd0, 8'd0);
    send_data(8'h5A);
    send_data(8'hFF);
    directed_items = sent;
    drain();

    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_tbl[p];
      stall_pct = stall_tbl[p];
      while (sent < directed_items + (p + 1) * RANDOM_ITEMS / 4) random_frame();
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d requests (%0d directed) through four idle and stall phases.",
             sent, directed_items);
    $display("Checked %0d output bytes: %0d complete frames, %0d error results.",
             results_seen, frames_seen, errors_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/cfb_pkg.sv
rtl/cfb_in_if.sv
rtl/cfb_out_if.sv
rtl/cfb_builder.sv
rtl/cfb_serializer.sv
rtl/command_frame_builder_sum16.sv
verif/cfb_frame_checker.sv
verif/command_frame_builder_sum16_tb.sv
